// File: rtl/core/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// shared widths, codes and types of the sorted table binary search block
// ----------------------------------------------------------------------------
package sbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // item field widths
    localparam int ENTRY_W     = 10;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;

    // configuration port
    localparam int CFG_W       = 11;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRIES_IN_USE = 3'd0;

    // operation codes carried in tuser
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_entry;
        logic load_search;
        logic probe;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic range_empty;
        logic key_eq;
        logic out_free;
    } t_status;

endpackage

// File: rtl/core/sbs_ctrl.sv
// ----------------------------------------------------------------------------
// sbs_ctrl
// search sequencer: accepts items and steps the probe loop
// ----------------------------------------------------------------------------
module sbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_func,
    input  sbs_pkg::t_status i_status,
    output logic            o_s_tready,
    output sbs_pkg::t_cmd   o_cmd
);
    import sbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && (i_func == FUNC_SEARCH)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.range_empty ? ST_DONE : ST_CMP;
            end
            ST_CMP: begin
                n_state = i_status.key_eq ? ST_DONE : ST_CHECK;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready        = 1'b1;
                o_cmd.wr_entry    = i_s_tvalid && (i_func == FUNC_WRITE);
                o_cmd.load_search = i_s_tvalid && (i_func == FUNC_SEARCH);
            end
            ST_CHECK: begin
                o_cmd.probe = !i_status.range_empty;
            end
            ST_CMP: begin
                o_cmd.update = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/sbs_datapath.sv
// ----------------------------------------------------------------------------
// sbs_datapath
// entry memory, search bounds, key compare and result register
// ----------------------------------------------------------------------------
module sbs_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbs_pkg::t_cmd               i_cmd,
    input  logic [sbs_pkg::ENTRY_W-1:0] i_entry_index,
    input  logic [sbs_pkg::VALUE_W-1:0] i_operand_value,
    input  logic [sbs_pkg::CNT_W-1:0]   i_count,
    input  logic                        i_m_tready,
    output sbs_pkg::t_status            o_status,
    output logic                        o_m_tvalid,
    output logic                        o_found,
    output logic [sbs_pkg::POS_W-1:0]   o_position
);
    import sbs_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;
    logic signed [VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]          r_lo;
    logic [CNT_W-1:0]          r_hi_p1;    // high bound plus one
    logic [IDX_W-1:0]          r_mid;
    logic                      r_found;
    logic                      r_out_valid;
    logic                      r_out_found;
    logic [POS_W-1:0]          r_out_pos;

    logic [CNT_W:0]            w_sum;
    logic [IDX_W-1:0]          w_mid;
    logic                      w_wr_ok;

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hi_p1} - (CNT_W+1)'(1);
    assign w_mid   = w_sum[IDX_W:1];
    assign w_wr_ok = (32'(i_entry_index) < 32'(TABLE_DEPTH));

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && w_wr_ok) begin
            r_mem[IDX_W'(i_entry_index)] <= i_operand_value;
        end
        if (i_cmd.probe) begin
            r_rdata <= r_mem[w_mid];
        end
    end

    // bounds and key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_search) begin
            r_key   <= i_operand_value;
            r_lo    <= '0;
            r_hi_p1 <= i_count;
            r_found <= 1'b0;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.update) begin
            if (r_key == r_rdata) begin
                r_found <= 1'b1;
            end else if (r_key < r_rdata) begin
                r_hi_p1 <= CNT_W'(r_mid);
            end else begin
                r_lo    <= CNT_W'(r_mid) + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found <= r_found;
            r_out_pos   <= r_found ? POS_W'(r_mid) : '0;
        end
    end

    assign o_status.range_empty = (r_lo >= r_hi_p1);
    assign o_status.key_eq      = (r_key == r_rdata);
    assign o_status.out_free    = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule

// File: rtl/core/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// binary search over a table of signed 32-bit entries kept in ascending order
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores operand_value at entry_index and gives no
// result. A search item (tuser 1) runs the classic binary search over
// entries 0 to entries_in_use-1 and gives one result: found in tuser,
// position in tdata (zero when not found). Each probe first reads the
// entry memory (ST_CHECK), then compares and moves a bound (ST_CMP); a
// search makes at most eleven probes on a full 1024-entry table and none
// on an empty one. Searches run one at a time; the input is ready again
// once the result sits in the output register, so the next item is taken
// while that result waits. entries_in_use is written through the APB port
// at address 0; the user must write it only while the block is idle, as
// the block itself does not enforce this. Counts above the table depth
// are treated as the full table.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [sbs_pkg::S_TDATA_W-1:0]     i_s_tdata,  // entry_index, operand_value
    input  logic                              i_s_tuser,  // func
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sbs_pkg::M_TDATA_W-1:0]     o_m_tdata,  // position
    output logic                              o_m_tuser,  // found
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sbs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sbs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import sbs_pkg::*;

    logic [CFG_W-1:0]   r_entries_in_use;
    logic [CNT_W-1:0]   w_count;
    logic [ENTRY_W-1:0] w_entry_index;
    logic [VALUE_W-1:0] w_operand_value;
    logic [POS_W-1:0]   w_position;
    t_cmd               w_cmd;
    t_status            w_status;

    // unpack the input item
    assign w_entry_index   = i_s_tdata[ENTRY_W-1:0];
    assign w_operand_value = i_s_tdata[ENTRY_W +: VALUE_W];

    // register file: a single count register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ENTRIES_IN_USE) ? APB_DATA_W'(r_entries_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_ENTRIES_IN_USE)) begin
            r_entries_in_use <= pwdata[CFG_W-1:0];
        end
    end

    // clamp the count to the table depth
    always_comb begin
        if (32'(r_entries_in_use) > 32'(TABLE_DEPTH)) begin
            w_count = CNT_W'(TABLE_DEPTH);
        end else begin
            w_count = CNT_W'(r_entries_in_use);
        end
    end

    sbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (i_s_tuser),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    sbs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_entry_index   (w_entry_index),
        .i_operand_value (w_operand_value),
        .i_count         (w_count),
        .i_m_tready      (i_m_tready),
        .o_status        (w_status),
        .o_m_tvalid      (o_m_tvalid),
        .o_found         (o_m_tuser),
        .o_position      (w_position)
    );

    // pack the result item: position in the low bits, zero fill above
    assign o_m_tdata = M_TDATA_W'(w_position);

endmodule

// File: rtl/core/sbs_checker.sv
// ----------------------------------------------------------------------------
// sbs_checker
// port-level checks of the sorted table binary search block
// ----------------------------------------------------------------------------
module sbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [sbs_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                          o_m_tuser
);
    import sbs_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss with nonzero position");

    // a search item blocks the input while it runs
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == FUNC_SEARCH) |=> !o_s_tready)
        else $error("input ready during a search");

    // a write item completes at once
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == FUNC_WRITE) |=> o_s_tready)
        else $error("input stalled after a write");

    // no result appears the cycle after a search is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == FUNC_SEARCH) |=> !$rose(o_m_tvalid))
        else $error("result too early");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
